[rtl/dual_servo_pwm_generator_defines.svh]
// Assertion macros for the dual servo PWM generator.
// Needs clk and arst_n in the scope of the module that uses them.
`ifndef DUAL_SERVO_PWM_GENERATOR_DEFINES_SVH
`define DUAL_SERVO_PWM_GENERATOR_DEFINES_SVH

// Plain property, checked at every clock edge outside reset.
`define DSPG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a result in the next cycle.
`define DSPG_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[rtl/dspg_pkg.sv]
// Shared types and constants of the dual servo PWM generator.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package dspg_pkg;

	localparam int ANGLE_W = 18;
	localparam int WRAP_W = 6;
	localparam int DELTA_W = 11;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam int COUNTER_BITS_DEF = 8;
	localparam int WIDTH_BITS_DEF = 11;

	localparam logic [WRAP_W-1:0] PERIOD_RESET = 6'd39;

	localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -18'sd90000;
	localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 18'sd90000;
	localparam logic [ANGLE_W-1:0] ANGLE_OFS = 18'd90000;

	localparam int PW_MIN = 50;
	localparam int PW_MAX = 1750;
	localparam int CENTER_WIDTH = 900;

	// floor(u * 1700 / 180000) as (u * MAP_MUL) >> MAP_SHIFT, exact for u <= 180000.
	localparam int MAP_MUL_W = 23;
	localparam logic [MAP_MUL_W-1:0] MAP_MUL = 23'd5070448;
	localparam int MAP_SHIFT = 29;
	localparam int MAP_PROD_W = ANGLE_W + MAP_MUL_W;

	// floor(d * 180000 / 1700) as (d * BACK_MUL) >> BACK_SHIFT, exact for d <= 1700.
	localparam int BACK_MUL_W = 23;
	localparam logic [BACK_MUL_W-1:0] BACK_MUL = 23'd6939106;
	localparam int BACK_SHIFT = 16;
	localparam int BACK_PROD_W = DELTA_W + BACK_MUL_W;

	typedef enum logic [1:0] {
		ACT_TICK     = 2'd0,
		ACT_SET_PAN  = 2'd1,
		ACT_SET_TILT = 2'd2
	} action_t;

	typedef enum logic [0:0] {
		REG_PERIOD_OVERFLOWS = 1'b0
	} reg_idx_t;

	// Everything the first stage hands to the result stage.
	typedef struct packed {
		logic               pan;
		logic               tilt;
		logic               start;
		logic               is_set;
		logic [DELTA_W-1:0] delta;
	} stage_t;

endpackage

`default_nettype wire

[rtl/dspg_channels_if.sv]
// Valid/ready channel interfaces for command words and result words.
// Depends on dspg_pkg for the field widths.
`default_nettype none

interface dspg_cmd_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          action;
	logic signed [dspg_pkg::ANGLE_W-1:0] angle_mdeg;

	modport source (output valid, action, angle_mdeg, input ready);
	modport sink (input valid, action, angle_mdeg, output ready);
endinterface

interface dspg_res_if;
	logic                                valid;
	logic                                ready;
	logic                                pan_pulse;
	logic                                tilt_pulse;
	logic                                period_start;
	logic signed [dspg_pkg::ANGLE_W-1:0] readback_mdeg;

	modport source (output valid, pan_pulse, tilt_pulse, period_start, readback_mdeg,
		input ready);
	modport sink (input valid, pan_pulse, tilt_pulse, period_start, readback_mdeg,
		output ready);
endinterface

`default_nettype wire

[rtl/dual_servo_pwm_generator.sv]
// Top level of the dual servo PWM generator: counters, pulse levels, angle mapping.
// Depends on dspg_pkg, the channels in dspg_channels_if.sv and the assertion header.
//
// Usage: every word on cmd is either a timer tick or a set command for the pan or
// the tilt channel. Each accepted word yields exactly one word on res: both pin
// levels after the word, a period start flag, and on set commands the angle
// mapped back from the quantized pulse width (zero otherwise).
// Throughput is one word per clock while res is ready. An accepted command is
// registered in the first stage, and its result then in the output register of
// the result stage: the first stage updates the counters, levels and pending widths and
// does the angle-to-width multiply; the result stage does the width-to-angle
// multiply into the output register.
// When res stalls, the pipeline holds; cmd is still ready while the first stage is
// empty, so one more word is taken while a finished result waits.
// period_overflows is written through the APB port at byte address 0 and should
// only change while no command is in flight.
// Reset clears the counters, centers all widths at 900 ticks, drives both pins
// high, sets period_overflows to 39 and empties the pipeline.
`default_nettype none
`include "dual_servo_pwm_generator_defines.svh"

module dual_servo_pwm_generator #(
	parameter int COUNTER_BITS = dspg_pkg::COUNTER_BITS_DEF,
	parameter int WIDTH_BITS = dspg_pkg::WIDTH_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	dspg_cmd_if.sink                               cmd,
	dspg_res_if.source                             res,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [dspg_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [dspg_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [dspg_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready
);

	localparam int POS_W = dspg_pkg::WRAP_W + COUNTER_BITS;
	localparam int CMP_W = (POS_W > WIDTH_BITS) ? POS_W : WIDTH_BITS;

	// Configuration register.
	logic [dspg_pkg::WRAP_W-1:0] period_q;

	// Block state.
	logic [COUNTER_BITS-1:0]     tick_q, tick_d;
	logic [dspg_pkg::WRAP_W-1:0] wrap_q, wrap_d;
	logic [WIDTH_BITS-1:0]       pan_act_q, pan_act_d, tilt_act_q, tilt_act_d;
	logic [WIDTH_BITS-1:0]       pan_pend_q, pan_pend_d, tilt_pend_q, tilt_pend_d;
	logic                        pan_lvl_q, pan_lvl_d, tilt_lvl_q, tilt_lvl_d;

	// Pipeline.
	dspg_pkg::stage_t              st_d, st_s1;
	logic                          valid_s1, valid_s2;
	logic                          adv_s1, adv_s2, acc;
	logic                          pan_s2, tilt_s2, start_s2;
	logic [dspg_pkg::ANGLE_W-1:0]  rb_d, rb_s2;

	// Tick path.
	logic [COUNTER_BITS-1:0]     tick_inc;
	logic [dspg_pkg::WRAP_W-1:0] wrap_inc, wrap_nx;
	logic                        wrapped, start_nx;
	logic [WIDTH_BITS-1:0]       pan_act_nx, tilt_act_nx;
	logic [POS_W-1:0]            pos;
	logic                        pan_tick_lvl, tilt_tick_lvl;

	// Angle mapping.
	logic signed [dspg_pkg::ANGLE_W-1:0] a_sat;
	logic [dspg_pkg::ANGLE_W-1:0]        u;
	logic [dspg_pkg::MAP_PROD_W-1:0]     map_prod;
	logic [dspg_pkg::DELTA_W-1:0]        delta;
	logic [WIDTH_BITS-1:0]               width_new;
	logic [dspg_pkg::BACK_PROD_W-1:0]    back_prod;
	logic [dspg_pkg::ANGLE_W-1:0]        back_q;

	logic cfg_we;

	// Handshake: the result register frees itself when taken, the first stage
	// frees itself when it can move on.
	assign adv_s2 = !valid_s2 || res.ready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign cmd.ready = adv_s1;
	assign acc = cmd.valid && cmd.ready;

	// APB register port.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready &&
		(dspg_pkg::reg_idx_t'(paddr[2]) == dspg_pkg::REG_PERIOD_OVERFLOWS);

	always_comb begin
		case (dspg_pkg::reg_idx_t'(paddr[2]))
			dspg_pkg::REG_PERIOD_OVERFLOWS: prdata = dspg_pkg::APB_DATA_W'(period_q);
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= dspg_pkg::PERIOD_RESET;
		end else if (cfg_we) begin
			period_q <= pwdata[dspg_pkg::WRAP_W-1:0];
		end
	end

	// Tick path. A zero period register compares as one, so every wrap starts
	// a period; a lowered register ends the period at the next wrap.
	assign tick_inc = tick_q + 1'b1;
	assign wrapped = (tick_inc == '0);
	assign wrap_inc = wrap_q + 1'b1;
	assign start_nx = wrapped && (wrap_inc >= period_q);
	assign wrap_nx = start_nx ? '0 : (wrapped ? wrap_inc : wrap_q);
	assign pan_act_nx = start_nx ? pan_pend_q : pan_act_q;
	assign tilt_act_nx = start_nx ? tilt_pend_q : tilt_act_q;
	assign pos = {wrap_nx, tick_inc};
	assign pan_tick_lvl = (start_nx || pan_lvl_q) && !(CMP_W'(pos) >= CMP_W'(pan_act_nx));
	assign tilt_tick_lvl = (start_nx || tilt_lvl_q) &&
		!(CMP_W'(pos) >= CMP_W'(tilt_act_nx));

	// Angle to width: saturate, offset to 0..180000, scale by 17/1800.
	always_comb begin
		if (cmd.angle_mdeg < dspg_pkg::ANGLE_MIN) begin
			a_sat = dspg_pkg::ANGLE_MIN;
		end else if (cmd.angle_mdeg > dspg_pkg::ANGLE_MAX) begin
			a_sat = dspg_pkg::ANGLE_MAX;
		end else begin
			a_sat = cmd.angle_mdeg;
		end
	end

	assign u = unsigned'(a_sat) + dspg_pkg::ANGLE_OFS;
	assign map_prod = dspg_pkg::MAP_PROD_W'(u) * dspg_pkg::MAP_PROD_W'(dspg_pkg::MAP_MUL);
	assign delta = map_prod[dspg_pkg::MAP_SHIFT +: dspg_pkg::DELTA_W];
	assign width_new = WIDTH_BITS'(delta) + WIDTH_BITS'(dspg_pkg::PW_MIN);

	// Next state and first-stage word.
	always_comb begin
		tick_d = tick_q;
		wrap_d = wrap_q;
		pan_act_d = pan_act_q;
		tilt_act_d = tilt_act_q;
		pan_pend_d = pan_pend_q;
		tilt_pend_d = tilt_pend_q;
		pan_lvl_d = pan_lvl_q;
		tilt_lvl_d = tilt_lvl_q;
		st_d.start = 1'b0;
		st_d.is_set = 1'b0;
		st_d.delta = delta;
		case (dspg_pkg::action_t'(cmd.action))
			dspg_pkg::ACT_TICK: begin
				tick_d = tick_inc;
				wrap_d = wrap_nx;
				pan_act_d = pan_act_nx;
				tilt_act_d = tilt_act_nx;
				pan_lvl_d = pan_tick_lvl;
				tilt_lvl_d = tilt_tick_lvl;
				st_d.start = start_nx;
			end
			dspg_pkg::ACT_SET_PAN: begin
				pan_pend_d = width_new;
				st_d.is_set = 1'b1;
			end
			dspg_pkg::ACT_SET_TILT: begin
				tilt_pend_d = width_new;
				st_d.is_set = 1'b1;
			end
			default: ;
		endcase
		st_d.pan = pan_lvl_d;
		st_d.tilt = tilt_lvl_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			wrap_q <= '0;
			pan_act_q <= WIDTH_BITS'(dspg_pkg::CENTER_WIDTH);
			tilt_act_q <= WIDTH_BITS'(dspg_pkg::CENTER_WIDTH);
			pan_pend_q <= WIDTH_BITS'(dspg_pkg::CENTER_WIDTH);
			tilt_pend_q <= WIDTH_BITS'(dspg_pkg::CENTER_WIDTH);
			pan_lvl_q <= 1'b1;
			tilt_lvl_q <= 1'b1;
		end else if (acc) begin
			tick_q <= tick_d;
			wrap_q <= wrap_d;
			pan_act_q <= pan_act_d;
			tilt_act_q <= tilt_act_d;
			pan_pend_q <= pan_pend_d;
			tilt_pend_q <= tilt_pend_d;
			pan_lvl_q <= pan_lvl_d;
			tilt_lvl_q <= tilt_lvl_d;
		end
	end

	// Result stage: width back to angle, scale by 1800/17 and remove the offset.
	assign back_prod = dspg_pkg::BACK_PROD_W'(st_s1.delta) *
		dspg_pkg::BACK_PROD_W'(dspg_pkg::BACK_MUL);
	assign back_q = back_prod[dspg_pkg::BACK_SHIFT +: dspg_pkg::ANGLE_W];
	assign rb_d = st_s1.is_set ? (back_q - dspg_pkg::ANGLE_OFS) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= cmd.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			st_s1 <= st_d;
		end
		if (adv_s2) begin
			pan_s2 <= st_s1.pan;
			tilt_s2 <= st_s1.tilt;
			start_s2 <= st_s1.start;
			rb_s2 <= rb_d;
		end
	end

	assign res.valid = valid_s2;
	assign res.pan_pulse = pan_s2;
	assign res.tilt_pulse = tilt_s2;
	assign res.period_start = start_s2;
	assign res.readback_mdeg = signed'(rb_s2);

	// A new period starts at position zero, below every legal width.
	`DSPG_ASSERT(a_start_high,
		!(res.valid && res.period_start) || (res.pan_pulse && res.tilt_pulse),
		"period start word with a low pin")
	`DSPG_ASSERT(a_pend_range,
		(pan_pend_q >= WIDTH_BITS'(dspg_pkg::PW_MIN)) &&
		(pan_pend_q <= WIDTH_BITS'(dspg_pkg::PW_MAX)) &&
		(tilt_pend_q >= WIDTH_BITS'(dspg_pkg::PW_MIN)) &&
		(tilt_pend_q <= WIDTH_BITS'(dspg_pkg::PW_MAX)),
		"pending width out of range")
	`DSPG_ASSERT_NEXT(a_start_clears,
		acc && (dspg_pkg::action_t'(cmd.action) == dspg_pkg::ACT_TICK) && start_nx,
		(tick_q == '0) && (wrap_q == '0),
		"counters not cleared at period start")
	`DSPG_ASSERT(a_rb_range,
		!res.valid || ((res.readback_mdeg >= dspg_pkg::ANGLE_MIN) &&
		(res.readback_mdeg <= dspg_pkg::ANGLE_MAX)),
		"readback angle out of range")

endmodule

`default_nettype wire
